FILE: rtl/core/ddpm_pkg.sv
// ----------------------------------------------------------------------------
// ddpm_pkg - shared types and constants of the differential-drive mixer
// Widths, the percent limit, the reciprocal for the divide by 100 and the
// words that travel between the front end, the divider cells and the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ddpm_pkg;

   // command and result widths
   localparam int CMD_W      = 16;
   localparam int PERIOD_W   = 16;
   localparam int CMP_W      = 16;

   // percent limit and reset period
   localparam int LIMIT_PCT  = 100;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd7200;

   // clamped command (+-100) and mixed power (+-200)
   localparam int CLAMP_W    = 9;
   // magnitude of mixed power, 0..200
   localparam int MAG_W      = 8;
   // duty percentage out of the divider, 0..100
   localparam int QUOT_W     = 7;
   // magnitude * 100, up to 20000
   localparam int DIVIDEND_W = 15;

   // period * duty, up to 6553500
   localparam int PROD_W     = PERIOD_W + QUOT_W;
   // x / 100 == (x * RECIP) >> RECIP_SHIFT, exact for x below 2**23
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;
   localparam int FULL_W      = PROD_W + RECIP_W;

   // word handed from cell to cell through the divider row
   typedef struct packed {
      logic [DIVIDEND_W-1:0] rem_l;
      logic [DIVIDEND_W-1:0] rem_r;
      logic [QUOT_W-1:0]     quot_l;
      logic [QUOT_W-1:0]     quot_r;
      logic [DIVIDEND_W-1:0] div_sh;
      logic                  left_pos;
      logic                  right_pos;
   } div_word_type;

   // result word
   typedef struct packed {
      logic [CMP_W-1:0] left_back_compare;
      logic [CMP_W-1:0] left_fwd_compare;
      logic [CMP_W-1:0] right_back_compare;
      logic [CMP_W-1:0] right_fwd_compare;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/ddpm_if.sv
// ----------------------------------------------------------------------------
// ddpm_if - valid/ready channels of the mixer
// Command channel (speed, yaw) and result channel (four compare values).
// ----------------------------------------------------------------------------
`default_nettype none

interface ddpm_req_if;
   import ddpm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] speed_cmd;
   logic signed [CMD_W-1:0] yaw_cmd;

   modport source (output valid, output speed_cmd, output yaw_cmd, input ready);
   modport sink   (input valid, input speed_cmd, input yaw_cmd, output ready);
endinterface

interface ddpm_rsp_if;
   import ddpm_pkg::*;

   logic             valid;
   logic             ready;
   logic [CMP_W-1:0] left_back_compare;
   logic [CMP_W-1:0] left_fwd_compare;
   logic [CMP_W-1:0] right_back_compare;
   logic [CMP_W-1:0] right_fwd_compare;

   modport source (output valid, output left_back_compare, output left_fwd_compare,
                   output right_back_compare, output right_fwd_compare, input ready);
   modport sink   (input valid, input left_back_compare, input left_fwd_compare,
                   input right_back_compare, input right_fwd_compare, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/differential_drive_pwm_mixer_top.sv
// Pipeline: an accepted command word passes through every stage to its result word
//   (1 front-end stage, 7 divider cells, 2 scaling stages).
// Throughput: one word per cycle; each stage holds one word and takes the
//   next whenever it is empty or its own word moves on.
// Reset: synchronous, clears every stage valid and sets the period to 7200.
// ----------------------------------------------------------------------------
// differential_drive_pwm_mixer_top - arcade-drive mixer with normalization
// Clamps speed and yaw, mixes to left/right power, normalizes to 100 % in a
// row of divider cells and converts each duty into a PWM compare value.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_pwm_mixer_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ddpm_req_if.sink                           req_chan,
   ddpm_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [ddpm_pkg::PERIOD_W-1:0] csr_wr_data
);
   import ddpm_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_in;
   div_word_type        word_s  [QUOT_W+1];
   logic                valid_s [QUOT_W+1];
   logic                ready_s [QUOT_W+1];
   rsp_word_type        rsp_word;

   // period register
   assign period_in = csr_wr_en ? csr_wr_data : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // clamp and mix
   ddpm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .valid_i     (req_chan.valid),
      .speed_cmd_i (req_chan.speed_cmd),
      .yaw_cmd_i   (req_chan.yaw_cmd),
      .ready_o     (req_chan.ready),
      .valid_o     (valid_s[0]),
      .word_o      (word_s[0]),
      .ready_i     (ready_s[0])
   );

   // divider row, one quotient bit per cell
   for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
      ddpm_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_s[i]),
         .word_i  (word_s[i]),
         .ready_o (ready_s[i]),
         .valid_o (valid_s[i+1]),
         .word_o  (word_s[i+1]),
         .ready_i (ready_s[i+1])
      );
   end

   // compare value scaling and output register
   ddpm_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .valid_i  (valid_s[QUOT_W]),
      .word_i   (word_s[QUOT_W]),
      .period_i (period_ff),
      .ready_o  (ready_s[QUOT_W]),
      .valid_o  (rsp_chan.valid),
      .word_o   (rsp_word),
      .ready_i  (rsp_chan.ready)
   );

   assign rsp_chan.left_back_compare  = rsp_word.left_back_compare;
   assign rsp_chan.left_fwd_compare   = rsp_word.left_fwd_compare;
   assign rsp_chan.right_back_compare = rsp_word.right_back_compare;
   assign rsp_chan.right_fwd_compare  = rsp_word.right_fwd_compare;

endmodule

`default_nettype wire

FILE: rtl/core/ddpm_front.sv
// ----------------------------------------------------------------------------
// ddpm_front - clamp, mix and divider set-up
// Saturates both commands, mixes them into left/right power, takes the
// magnitudes and loads the first word of the divider row.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpm_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          valid_i,
   input  wire logic signed [ddpm_pkg::CMD_W-1:0] speed_cmd_i,
   input  wire logic signed [ddpm_pkg::CMD_W-1:0] yaw_cmd_i,
   output      logic                          ready_o,
   output      logic                          valid_o,
   output      ddpm_pkg::div_word_type        word_o,
   input  wire logic                          ready_i
);
   import ddpm_pkg::*;

   logic signed [CLAMP_W-1:0] speed_c;
   logic signed [CLAMP_W-1:0] yaw_c;
   logic signed [CLAMP_W-1:0] left_pwr;
   logic signed [CLAMP_W-1:0] right_pwr;
   logic [MAG_W-1:0]          left_mag;
   logic [MAG_W-1:0]          right_mag;
   logic [MAG_W-1:0]          max_mag;
   logic [MAG_W-1:0]          divisor;
   div_word_type              word_in;
   div_word_type              word_ff;
   logic                      valid_ff;

   // saturate commands to +-100
   always_comb begin
      if (speed_cmd_i > CMD_W'(LIMIT_PCT)) begin
         speed_c = CLAMP_W'(LIMIT_PCT);
      end else if (speed_cmd_i < -CMD_W'(LIMIT_PCT)) begin
         speed_c = -CLAMP_W'(LIMIT_PCT);
      end else begin
         speed_c = CLAMP_W'(speed_cmd_i);
      end
      if (yaw_cmd_i > CMD_W'(LIMIT_PCT)) begin
         yaw_c = CLAMP_W'(LIMIT_PCT);
      end else if (yaw_cmd_i < -CMD_W'(LIMIT_PCT)) begin
         yaw_c = -CLAMP_W'(LIMIT_PCT);
      end else begin
         yaw_c = CLAMP_W'(yaw_cmd_i);
      end
   end

   // mix and take magnitudes
   assign left_pwr  = speed_c - yaw_c;
   assign right_pwr = speed_c + yaw_c;
   assign left_mag  = left_pwr[CLAMP_W-1]  ? MAG_W'(-left_pwr)  : MAG_W'(left_pwr);
   assign right_mag = right_pwr[CLAMP_W-1] ? MAG_W'(-right_pwr) : MAG_W'(right_pwr);
   assign max_mag   = (left_mag > right_mag) ? left_mag : right_mag;

   // below the limit, divide by 100: magnitude * 100 / 100 gives it back
   assign divisor = (max_mag > MAG_W'(LIMIT_PCT)) ? max_mag : MAG_W'(LIMIT_PCT);

   always_comb begin
      word_in.rem_l     = DIVIDEND_W'(left_mag)  * DIVIDEND_W'(LIMIT_PCT);
      word_in.rem_r     = DIVIDEND_W'(right_mag) * DIVIDEND_W'(LIMIT_PCT);
      word_in.quot_l    = '0;
      word_in.quot_r    = '0;
      word_in.div_sh    = DIVIDEND_W'(divisor) << (QUOT_W - 1);
      word_in.left_pos  = !left_pwr[CLAMP_W-1]  && (left_pwr != '0);
      word_in.right_pos = !right_pwr[CLAMP_W-1] && (right_pwr != '0);
   end

   // stage register
   assign ready_o = !valid_ff || ready_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         word_ff <= word_in;
      end
   end

   assign valid_o = valid_ff;
   assign word_o  = word_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ddpm_div_cell.sv
// ----------------------------------------------------------------------------
// ddpm_div_cell - one quotient bit of the restoring divider row
// Both sides share the divisor; each cell trial-subtracts the aligned
// divisor, shifts in one quotient bit and moves the divisor down a place.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpm_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   valid_i,
   input  wire ddpm_pkg::div_word_type word_i,
   output      logic                   ready_o,
   output      logic                   valid_o,
   output      ddpm_pkg::div_word_type word_o,
   input  wire logic                   ready_i
);
   import ddpm_pkg::*;

   div_word_type word_in;
   div_word_type word_ff;
   logic         valid_ff;
   logic         fit_l;
   logic         fit_r;

   // trial subtract on both lanes
   assign fit_l = word_i.rem_l >= word_i.div_sh;
   assign fit_r = word_i.rem_r >= word_i.div_sh;

   always_comb begin
      word_in        = word_i;
      word_in.rem_l  = fit_l ? word_i.rem_l - word_i.div_sh : word_i.rem_l;
      word_in.rem_r  = fit_r ? word_i.rem_r - word_i.div_sh : word_i.rem_r;
      word_in.quot_l = {word_i.quot_l[QUOT_W-2:0], fit_l};
      word_in.quot_r = {word_i.quot_r[QUOT_W-2:0], fit_r};
      word_in.div_sh = word_i.div_sh >> 1;
   end

   // stage register
   assign ready_o = !valid_ff || ready_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_o) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_o && valid_i) begin
         word_ff <= word_in;
      end
   end

   assign valid_o = valid_ff;
   assign word_o  = word_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ddpm_scale.sv
// ----------------------------------------------------------------------------
// ddpm_scale - duty to compare value
// Stage A multiplies the period by the duty; stage B divides by 100 through
// a reciprocal multiply and steers each side onto its forward or back channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpm_scale (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             valid_i,
   input  wire ddpm_pkg::div_word_type           word_i,
   input  wire logic [ddpm_pkg::PERIOD_W-1:0]    period_i,
   output      logic                             ready_o,
   output      logic                             valid_o,
   output      ddpm_pkg::rsp_word_type           word_o,
   input  wire logic                             ready_i
);
   import ddpm_pkg::*;

   logic [PROD_W-1:0] prod_l_in;
   logic [PROD_W-1:0] prod_r_in;
   logic [PROD_W-1:0] prod_l_ff;
   logic [PROD_W-1:0] prod_r_ff;
   logic              left_pos_ff;
   logic              right_pos_ff;
   logic              valid_a_ff;
   logic              ready_a;
   logic [FULL_W-1:0] full_l;
   logic [FULL_W-1:0] full_r;
   logic [CMP_W-1:0]  cmp_l;
   logic [CMP_W-1:0]  cmp_r;
   rsp_word_type      rsp_in;
   rsp_word_type      rsp_ff;
   logic              valid_b_ff;
   logic              ready_b;

   // stage A: period * duty
   assign prod_l_in = PROD_W'(period_i) * PROD_W'(word_i.quot_l);
   assign prod_r_in = PROD_W'(period_i) * PROD_W'(word_i.quot_r);

   assign ready_b = !valid_b_ff || ready_i;
   assign ready_a = !valid_a_ff || ready_b;
   assign ready_o = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (ready_a) begin
         valid_a_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && valid_i) begin
         prod_l_ff    <= prod_l_in;
         prod_r_ff    <= prod_r_in;
         left_pos_ff  <= word_i.left_pos;
         right_pos_ff <= word_i.right_pos;
      end
   end

   // stage B: divide by 100 with the reciprocal
   assign full_l = FULL_W'(prod_l_ff) * FULL_W'(RECIP);
   assign full_r = FULL_W'(prod_r_ff) * FULL_W'(RECIP);
   assign cmp_l  = full_l[RECIP_SHIFT +: CMP_W];
   assign cmp_r  = full_r[RECIP_SHIFT +: CMP_W];

   // positive power drives forward, zero or negative drives backward
   always_comb begin
      rsp_in.left_back_compare  = left_pos_ff  ? '0 : cmp_l;
      rsp_in.left_fwd_compare   = left_pos_ff  ? cmp_l : '0;
      rsp_in.right_back_compare = right_pos_ff ? '0 : cmp_r;
      rsp_in.right_fwd_compare  = right_pos_ff ? cmp_r : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (ready_b) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b && valid_a_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign valid_o = valid_b_ff;
   assign word_o  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ddpm_checker.sv
// ----------------------------------------------------------------------------
// ddpm_checker - port-level checks of the mixer
// Reset emptiness, output hold under stall and channel exclusivity.
// ----------------------------------------------------------------------------
`default_nettype none

module ddpm_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [ddpm_pkg::CMP_W-1:0]  left_back_compare,
   input wire logic [ddpm_pkg::CMP_W-1:0]  left_fwd_compare,
   input wire logic [ddpm_pkg::CMP_W-1:0]  right_back_compare,
   input wire logic [ddpm_pkg::CMP_W-1:0]  right_fwd_compare
);
   import ddpm_pkg::*;

   // reset empties the pipeline: no result, command side open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result valid or command side blocked after reset");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_back_compare)
         && $stable(left_fwd_compare) && $stable(right_back_compare)
         && $stable(right_fwd_compare))
      else $error("stalled result word changed");

   // at most one channel of the left side drives
   a_left_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (left_back_compare == '0) || (left_fwd_compare == '0))
      else $error("both left channels nonzero");

   // at most one channel of the right side drives
   a_right_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (right_back_compare == '0) || (right_fwd_compare == '0))
      else $error("both right channels nonzero");

endmodule

bind differential_drive_pwm_mixer_top ddpm_checker u_ddpm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .left_back_compare  (rsp_chan.left_back_compare),
   .left_fwd_compare   (rsp_chan.left_fwd_compare),
   .right_back_compare (rsp_chan.right_back_compare),
   .right_fwd_compare  (rsp_chan.right_fwd_compare)
);

`default_nettype wire
